// ----- hdl/lsrt_pkg.sv -----
// Shared constants, codes and control types of the record table block.
// No dependencies; imported by the controller, datapath and top level.
package lsrt_pkg;

   localparam int TABLE_DEPTH  = 1024;
   localparam int PAYLOAD_BITS = 64;
   localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);

   // operation codes
   localparam logic [1:0] KIND_SEARCH = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_ERASE  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_MISS   = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   // controller -> datapath commands
   typedef struct packed {
      logic       load;       // capture request, set scan start
      logic       scan;       // read entry at scan index, advance
      logic       shift;      // write lagging read data one entry down
      logic       append;     // write request record at fill count
      logic       dec;        // drop one record
      logic       res_wr;     // update pending result
      logic       res_hit;    // pending result takes lagging match
      logic [1:0] res_status;
      logic       out_load;   // move pending result to output registers
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       pos_bad;
      logic       scan_end;
      logic       lag_vld;
      logic       hit;
   } sts_type;

endpackage

// ----- hdl/lsrt_ctrl.sv -----
// Controller state machine of the record table: sequences search, insert,
// erase and the reply. Depends on lsrt_pkg.
module lsrt_ctrl import lsrt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_ERASE  = 3'd3;
   localparam logic [2:0] S_REPLY  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.kind)
               KIND_SEARCH: state_in = S_SEARCH;
               KIND_INSERT: begin
                  cmd.res_wr = 1'b1;
                  if (sts.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.append     = 1'b1;
                     cmd.res_status = ST_OK;
                  end
                  state_in = S_REPLY;
               end
               KIND_ERASE: begin
                  if (sts.pos_bad) begin
                     cmd.res_wr     = 1'b1;
                     cmd.res_status = ST_BADPOS;
                     state_in       = S_REPLY;
                  end else begin
                     state_in = S_ERASE;
                  end
               end
               default: begin
                  // unused code: no change, plain done
                  cmd.res_wr     = 1'b1;
                  cmd.res_status = ST_OK;
                  state_in       = S_REPLY;
               end
            endcase
         end
         S_SEARCH: begin
            if (sts.lag_vld && sts.hit) begin
               cmd.res_wr     = 1'b1;
               cmd.res_hit    = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_REPLY;
            end else if (sts.scan_end && !sts.lag_vld) begin
               cmd.res_wr     = 1'b1;
               cmd.res_status = ST_MISS;
               state_in       = S_REPLY;
            end else begin
               cmd.scan = !sts.scan_end;
            end
         end
         S_ERASE: begin
            cmd.shift = sts.lag_vld;
            cmd.scan  = !sts.scan_end;
            if (sts.scan_end && !sts.lag_vld) begin
               cmd.dec        = 1'b1;
               cmd.res_wr     = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_reply_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while waiting");
   a_accept_goes_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted item not decoded");
   a_one_write_kind: assert property (@(posedge clock) disable iff (reset)
      !(cmd.shift && cmd.append))
      else $error("shift and append in one cycle");

endmodule

// ----- hdl/lsrt_dp.sv -----
// Datapath of the record table: key and payload memories, fill count,
// scan index, compare and result registers. Depends on lsrt_pkg.
module lsrt_dp import lsrt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [1:0]           req_kind,
   input  logic [31:0]          req_key,
   input  logic [63:0]          req_payload,
   input  logic [IDX_BITS-1:0]  req_position,
   output logic [1:0]           rsp_status,
   output logic [IDX_BITS-1:0]  rsp_found_index,
   output logic [63:0]          rsp_found_payload,
   output logic [CNT_BITS-1:0]  rsp_record_count
);

   logic [31:0]             key_mem [TABLE_DEPTH];
   logic [PAYLOAD_BITS-1:0] pay_mem [TABLE_DEPTH];

   logic [1:0]              kind_ff;
   logic [31:0]             key_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [IDX_BITS-1:0]     pos_ff;
   logic [CNT_BITS-1:0]     count_ff;
   logic [CNT_BITS-1:0]     rd_idx_ff;
   logic                    lag_vld_ff;
   logic [IDX_BITS-1:0]     lag_idx_ff;
   logic [31:0]             key_rd_ff;
   logic [PAYLOAD_BITS-1:0] pay_rd_ff;
   logic [1:0]              res_status_ff;
   logic [IDX_BITS-1:0]     res_index_ff;
   logic [PAYLOAD_BITS-1:0] res_pay_ff;
   logic [1:0]              out_status_ff;
   logic [IDX_BITS-1:0]     out_index_ff;
   logic [PAYLOAD_BITS-1:0] out_pay_ff;
   logic [CNT_BITS-1:0]     out_count_ff;

   logic                    wr_en;
   logic [IDX_BITS-1:0]     wr_addr;
   logic [31:0]             wr_key;
   logic [PAYLOAD_BITS-1:0] wr_pay;

   // status to controller
   assign sts.kind     = kind_ff;
   assign sts.full     = (count_ff == CNT_BITS'(TABLE_DEPTH));
   assign sts.pos_bad  = ({1'b0, pos_ff} >= count_ff);
   assign sts.scan_end = (rd_idx_ff == count_ff);
   assign sts.lag_vld  = lag_vld_ff;
   assign sts.hit      = (key_rd_ff == key_ff);

   // request capture and scan index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff  <= req_key;
         pay_ff  <= req_payload[PAYLOAD_BITS-1:0];
         pos_ff  <= req_position;
         if (req_kind == KIND_ERASE) begin
            rd_idx_ff <= CNT_BITS'(req_position) + CNT_BITS'(1);
         end else begin
            rd_idx_ff <= '0;
         end
      end else if (cmd.scan) begin
         rd_idx_ff <= rd_idx_ff + CNT_BITS'(1);
      end
      lag_idx_ff <= rd_idx_ff[IDX_BITS-1:0];
   end

   // read lag flag and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         lag_vld_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         lag_vld_ff <= cmd.scan;
         if (cmd.append) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end else if (cmd.dec) begin
            count_ff <= count_ff - CNT_BITS'(1);
         end
      end
   end

   // single write port: append at the end, or shift one entry down
   assign wr_en   = cmd.append || cmd.shift;
   assign wr_addr = cmd.append ? count_ff[IDX_BITS-1:0] : lag_idx_ff - IDX_BITS'(1);
   assign wr_key  = cmd.append ? key_ff : key_rd_ff;
   assign wr_pay  = cmd.append ? pay_ff : pay_rd_ff;

   // memories, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         pay_mem[wr_addr] <= wr_pay;
      end
      if (cmd.scan) begin
         key_rd_ff <= key_mem[rd_idx_ff[IDX_BITS-1:0]];
         pay_rd_ff <= pay_mem[rd_idx_ff[IDX_BITS-1:0]];
      end
   end

   // pending result and output registers
   always_ff @(posedge clock) begin
      if (cmd.res_wr) begin
         res_status_ff <= cmd.res_status;
         if (cmd.res_hit) begin
            res_index_ff <= lag_idx_ff;
            res_pay_ff   <= pay_rd_ff;
         end else begin
            res_index_ff <= '0;
            res_pay_ff   <= '0;
         end
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_index_ff  <= res_index_ff;
         out_pay_ff    <= res_pay_ff;
         out_count_ff  <= count_ff;
      end
   end

   assign rsp_status        = out_status_ff;
   assign rsp_found_index   = out_index_ff;
   assign rsp_found_payload = 64'(out_pay_ff);
   assign rsp_record_count  = out_count_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(TABLE_DEPTH))
      else $error("fill count beyond table depth");
   a_lag_below_count: assert property (@(posedge clock) disable iff (reset)
      lag_vld_ff |-> ({1'b0, lag_idx_ff} < count_ff))
      else $error("read beyond fill count");
   a_scan_not_past_end: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (rd_idx_ff < count_ff))
      else $error("scan issued past fill count");

endmodule

// ----- hdl/linear_search_record_table.sv -----
// Top level of the record table with linear search.
// Depends on lsrt_pkg, lsrt_ctrl and lsrt_dp.
//
// Use: one item on the req_ channel (kind, key, payload, position) gives one
// result on the rsp_ channel (status, found_index, found_payload,
// record_count). Both channels are valid/ready; an item moves at a clock
// edge where valid and ready are both high.
// Timing: an item is taken only while no other item is at work. Every
// accepted item passes through accept, decode and reply; insert and rejected
// items finish there.
// A search reads one entry per cycle from the registered memory read port and
// compares it in the next cycle. An erase at position p moves each later
// entry down one per cycle through the single write port.
// Reset (synchronous, active high) empties the table at once: the fill count
// clears and no entry is read before it is written again.
// When the receiver stalls, the result waits in the output register; the
// next item is accepted and worked on, and its result waits until the output
// register is free.
module linear_search_record_table import lsrt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic signed [31:0]  req_key,
   input  logic [63:0]         req_payload,
   input  logic [9:0]          req_position,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [9:0]          rsp_found_index,
   output logic [63:0]         rsp_found_payload,
   output logic [10:0]         rsp_record_count
);

   cmd_type cmd;
   sts_type sts;

   lsrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lsrt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .req_position      (req_position),
      .rsp_status        (rsp_status),
      .rsp_found_index   (rsp_found_index),
      .rsp_found_payload (rsp_found_payload),
      .rsp_record_count  (rsp_record_count)
   );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for linear_search_record_table: drives search, insert,
// erase and unused-kind items, predicts each reply from a shadow of the table
// and compares them. Depends on lsrt_pkg and the linear_search_record_table RTL.
`timescale 1ns / 100ps

module tb_top;
   import lsrt_pkg::*;

   // kind 3 has no operation; the block ignores it
   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         QUIET_LIMIT  = 20000;
   localparam int         ITEMS_PHASE  = 135;
   localparam int         PRINT_LIMIT  = 50;
   localparam logic [63:0] PAY_MASK    = {64{1'b1}} >> (64 - PAYLOAD_BITS);

   typedef struct packed {
      logic [1:0]          status;
      logic [IDX_BITS-1:0] idx;
      logic [63:0]         payload;
      logic [CNT_BITS-1:0] count;
   } reply_type;

   // Shadow of the record table plus the replies still owed by the block
   class table_tracker;
      logic [31:0] key_mem [TABLE_DEPTH];
      logic [63:0] pay_mem [TABLE_DEPTH];
      int          fill;
      reply_type   pending [$];
      int          errors;
      int          n_search, n_hit, n_insert, n_full, n_erase, n_badpos, n_ignored;

      function new();
         fill = 0;
         errors = 0;
         n_search = 0; n_hit = 0; n_insert = 0; n_full = 0;
         n_erase = 0; n_badpos = 0; n_ignored = 0;
      endfunction

      // apply one accepted item to the shadow and queue the reply it owes
      function void note_request(logic [1:0] kind, logic [31:0] key,
                                 logic [63:0] payload, logic [9:0] position);
         reply_type want;
         int        i;
         bit        hit;
         want = '0;
         hit = 0;
         case (kind)
            KIND_SEARCH: begin
               n_search++;
               want.status = ST_MISS;
               i = 0;
               // lowest matching index wins
               while (i < fill && !hit) begin
                  if (key_mem[i] == key) begin
                     hit = 1;
                     want.status = ST_OK;
                     want.idx = IDX_BITS'(i);
                     want.payload = pay_mem[i];
                  end
                  i++;
               end
               if (hit) n_hit++;
            end
            KIND_INSERT: begin
               n_insert++;
               if (fill >= TABLE_DEPTH) begin
                  want.status = ST_FULL;
                  n_full++;
               end else begin
                  key_mem[fill] = key;
                  pay_mem[fill] = payload & PAY_MASK;
                  fill++;
               end
            end
            KIND_ERASE: begin
               n_erase++;
               if (int'(position) >= fill) begin
                  want.status = ST_BADPOS;
                  n_badpos++;
               end else begin
                  // close the gap: later records move down one
                  i = int'(position);
                  while (i + 1 < fill) begin
                     key_mem[i] = key_mem[i + 1];
                     pay_mem[i] = pay_mem[i + 1];
                     i++;
                  end
                  fill--;
               end
            end
            default: begin
               n_ignored++;
               want.status = ST_OK;
            end
         endcase
         want.count = CNT_BITS'(fill);
         pending.push_back(want);
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         if (errors < PRINT_LIMIT)
            $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
         errors++;
      endtask

      // compare one reply with the oldest one owed
      task check_reply(logic [1:0] status, logic [IDX_BITS-1:0] idx,
                       logic [63:0] payload, logic [CNT_BITS-1:0] count);
         reply_type want;
         if (pending.size() == 0) begin
            report("reply with nothing owed", 64'd1, 64'd0);
         end else begin
            want = pending.pop_front();
            if (status !== want.status)
               report("status", 64'(status), 64'(want.status));
            if (idx !== want.idx)
               report("found_index", 64'(idx), 64'(want.idx));
            if (payload !== want.payload)
               report("found_payload", payload, want.payload);
            if (count !== want.count)
               report("record_count", 64'(count), 64'(want.count));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_kind;
   logic signed [31:0]  req_key;
   logic [63:0]         req_payload;
   logic [9:0]          req_position;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_status;
   logic [9:0]          rsp_found_index;
   logic [63:0]         rsp_found_payload;
   logic [10:0]         rsp_record_count;

   table_tracker tracker;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           quiet_cycles = 0;

   linear_search_record_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_index   (rsp_found_index),
      .rsp_found_payload (rsp_found_payload),
      .rsp_record_count  (rsp_record_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random back-pressure, updated on the falling edge
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // reply monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_reply(rsp_status, rsp_found_index, rsp_found_payload,
                             rsp_record_count);
   end

   // watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      @(posedge clock);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Offer one item; called at a falling edge, returns at the falling edge
   // after acceptance. Valid stays high into the next item unless a gap is drawn.
   task automatic send_item(logic [1:0] kind, logic [31:0] key, logic [63:0] payload,
                            logic [9:0] position);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_kind     = kind;
      req_key      = key;
      req_payload  = payload;
      req_position = position;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(kind, key, payload, position);
      @(negedge clock);
   endtask

   // One random item, shaped to keep the table small with frequent hits
   task automatic random_item(output bit counted);
      int          r;
      int          ins_w;
      logic [1:0]  kind;
      logic [31:0] key;
      logic [63:0] payload;
      logic [9:0]  position;
      r        = $urandom_range(99);
      ins_w    = (tracker.fill < 8) ? 45 : ((tracker.fill > 40) ? 15 : 30);
      payload  = {$urandom, $urandom};
      position = 10'($urandom_range(1023));
      counted  = 1;
      // keys from a small pool collide often; the rest span all 32 bits
      if ($urandom_range(1)) begin
         case ($urandom_range(7))
            0: key = 32'h8000_0000;
            1: key = 32'h7fff_ffff;
            2: key = 32'h0000_0000;
            3: key = 32'hffff_ffff;
            default: key = 32'h0000_1000 + $urandom_range(7);
         endcase
      end else begin
         key = $urandom;
      end
      if (r < 4) begin
         kind = KIND_UNUSED;
         counted = 0;
      end else if (r < 4 + ins_w) begin
         kind = KIND_INSERT;
      end else if (r < 4 + ins_w + (96 - ins_w) / 2) begin
         kind = KIND_SEARCH;
      end else begin
         kind = KIND_ERASE;
      end
      if (kind == KIND_SEARCH && tracker.fill > 0 && $urandom_range(99) < 70)
         key = tracker.key_mem[$urandom_range(tracker.fill - 1)];
      if (kind == KIND_ERASE && tracker.fill > 0 && $urandom_range(99) < 85)
         position = 10'($urandom_range(tracker.fill - 1));
      if ($urandom_range(9) == 0)
         payload = $urandom_range(1) ? {64{1'b1}} : 64'd0;
      send_item(kind, key, payload, position);
   endtask

   initial begin
      int idle_tab  [4];
      int stall_tab [4];
      int done;
      bit counted;
      tracker        = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_SEARCH;
      req_key        = '0;
      req_payload    = '0;
      req_position   = '0;
      idle_tab  = '{0, 80, 0, 10};
      stall_tab = '{0, 0, 80, 10};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, key extremes, duplicates, erase at both ends
      send_item(KIND_SEARCH, 32'h0000_0000, 64'd0, 10'd0);
      send_item(KIND_ERASE, 32'h0, 64'd0, 10'd0);
      send_item(KIND_ERASE, 32'h0, 64'd0, 10'd1023);
      send_item(KIND_INSERT, 32'h8000_0000, 64'd0, 10'd0);
      send_item(KIND_INSERT, 32'h7fff_ffff, {64{1'b1}}, 10'd0);
      send_item(KIND_INSERT, 32'hffff_ffff, 64'h0123_4567_89ab_cdef, 10'd0);
      send_item(KIND_INSERT, 32'h0000_0000, 64'ha5a5_a5a5_5a5a_5a5a, 10'd0);
      send_item(KIND_INSERT, 32'h7fff_ffff, 64'h5555_5555_5555_5555, 10'd0);
      send_item(KIND_SEARCH, 32'h7fff_ffff, 64'd0, 10'd0);
      send_item(KIND_SEARCH, 32'h8000_0000, 64'd0, 10'd0);
      send_item(KIND_SEARCH, 32'h0000_0000, 64'd0, 10'd0);
      send_item(KIND_SEARCH, 32'h0000_3039, 64'd0, 10'd0);
      send_item(KIND_UNUSED, 32'hdead_beef, {64{1'b1}}, 10'h3ff);
      send_item(KIND_ERASE, 32'h0, 64'd0, 10'd5);
      send_item(KIND_ERASE, 32'h0, 64'd0, 10'd4);
      send_item(KIND_ERASE, 32'h0, 64'd0, 10'd0);
      send_item(KIND_SEARCH, 32'h7fff_ffff, 64'd0, 10'd0);
      send_item(KIND_ERASE, 32'h0, 64'd0, 10'd1);
      send_item(KIND_SEARCH, 32'hffff_ffff, 64'd0, 10'd0);
      send_item(KIND_ERASE, 32'h0, 64'd0, 10'd1);
      send_item(KIND_ERASE, 32'h0, 64'd0, 10'd0);
      send_item(KIND_SEARCH, 32'h7fff_ffff, 64'd0, 10'd0);

      // random items under each idling pattern
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_tab[p];
         recv_stall_pct = stall_tab[p];
         done = 0;
         while (done < ITEMS_PHASE) begin
            random_item(counted);
            done += counted;
         end
      end
      req_valid = 1'b0;

      // drain, then watch a little longer for stray replies
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d searches (%0d hits), %0d inserts (%0d into a full table),",
               tracker.n_search, tracker.n_hit, tracker.n_insert, tracker.n_full);
      $display("%0d erases (%0d at bad positions) and %0d ignored items",
               tracker.n_erase, tracker.n_badpos, tracker.n_ignored);
      if (tracker.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- linear_search_record_table.f -----
hdl/lsrt_pkg.sv
hdl/lsrt_ctrl.sv
hdl/lsrt_dp.sv
hdl/linear_search_record_table.sv
bench/tb_top.sv
